// File: src/cmfuv_pkg.sv
// shared types and constants for the cube map face and uv block
package cmfuv_pkg;

    localparam int IN_W            = 16;
    localparam int MAG_W           = 16;
    localparam int SUM_W           = 17;
    localparam int DIV_W           = 25;
    localparam int COORD_W         = 16;
    localparam int FRAC_BITS       = COORD_W;
    localparam int STEPS_PER_STAGE = 2;
    localparam int DIV_STAGES      = FRAC_BITS / STEPS_PER_STAGE;
    localparam int SCALE_NUM       = 499;
    localparam int SCALE_DEN       = 1000;

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } t_face;

    // selected face, face coordinates and major magnitude
    typedef struct packed {
        t_face                   face;
        logic                    zero;
        logic signed [SUM_W-1:0] a;
        logic signed [SUM_W-1:0] b;
        logic [MAG_W-1:0]        m;
    } t_sel;

    // divider state: running remainders and quotient bits for u and v
    typedef struct packed {
        t_face                face;
        logic                 zero;
        logic                 vsat;
        logic [DIV_W-1:0]     d;
        logic [DIV_W-1:0]     ru;
        logic [DIV_W-1:0]     rv;
        logic [FRAC_BITS-1:0] qu;
        logic [FRAC_BITS-1:0] qv;
    } t_div;

endpackage

// File: src/cmfuv_select.sv
// first stage: major axis pick, face coordinates and magnitude
module cmfuv_select (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [cmfuv_pkg::IN_W-1:0]     i_x,
    input  logic signed [cmfuv_pkg::IN_W-1:0]     i_y,
    input  logic signed [cmfuv_pkg::IN_W-1:0]     i_z,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output cmfuv_pkg::t_sel                       o_data
);

    logic signed [cmfuv_pkg::SUM_W-1:0] xe, ye, ze;
    logic signed [cmfuv_pkg::SUM_W-1:0] xn, yn, zn;
    logic [cmfuv_pkg::MAG_W-1:0]        ax, ay, az;
    logic                               r_valid;
    cmfuv_pkg::t_sel                    r_data;
    cmfuv_pkg::t_sel                    n_data;

    assign xe = {i_x[cmfuv_pkg::IN_W-1], i_x};
    assign ye = {i_y[cmfuv_pkg::IN_W-1], i_y};
    assign ze = {i_z[cmfuv_pkg::IN_W-1], i_z};
    assign xn = -xe;
    assign yn = -ye;
    assign zn = -ze;
    // magnitude of -32768 is 32768, which still fits 16 unsigned bits
    assign ax = i_x[cmfuv_pkg::IN_W-1] ? xn[cmfuv_pkg::MAG_W-1:0] : i_x;
    assign ay = i_y[cmfuv_pkg::IN_W-1] ? yn[cmfuv_pkg::MAG_W-1:0] : i_y;
    assign az = i_z[cmfuv_pkg::IN_W-1] ? zn[cmfuv_pkg::MAG_W-1:0] : i_z;

    always_comb begin
        n_data = '0;
        if (ax >= ay && ax >= az) begin
            n_data.m = ax;
            n_data.b = ye;
            if (i_x > 0) begin
                n_data.face = cmfuv_pkg::FACE_POS_X;
                n_data.a    = zn;
            end else begin
                n_data.face = cmfuv_pkg::FACE_NEG_X;
                n_data.a    = ze;
            end
        end else if (ay >= az) begin
            n_data.m = ay;
            n_data.a = xe;
            if (i_y > 0) begin
                n_data.face = cmfuv_pkg::FACE_POS_Y;
                n_data.b    = zn;
            end else begin
                n_data.face = cmfuv_pkg::FACE_NEG_Y;
                n_data.b    = ze;
            end
        end else begin
            n_data.m = az;
            n_data.b = ye;
            if (i_z > 0) begin
                n_data.face = cmfuv_pkg::FACE_POS_Z;
                n_data.a    = xe;
            end else begin
                n_data.face = cmfuv_pkg::FACE_NEG_Z;
                n_data.a    = xn;
            end
        end
        n_data.zero = (n_data.m == '0);
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/cmfuv_prep.sv
// second stage: shifted coordinates, scaled numerators and divisor
module cmfuv_prep (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cmfuv_pkg::t_sel   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output cmfuv_pkg::t_div   o_data
);

    logic [cmfuv_pkg::SUM_W:0]   sa_w, sb_w;
    logic [cmfuv_pkg::SUM_W-1:0] sa, sb;
    logic [cmfuv_pkg::DIV_W-1:0] pu, pv, d;
    logic                        r_valid;
    cmfuv_pkg::t_div             r_data;
    cmfuv_pkg::t_div             n_data;

    // both sums lie in [0, 2m]
    assign sa_w = {i_data.a[cmfuv_pkg::SUM_W-1], i_data.a} + {2'b00, i_data.m};
    assign sb_w = {i_data.b[cmfuv_pkg::SUM_W-1], i_data.b} + {2'b00, i_data.m};
    assign sa   = sa_w[cmfuv_pkg::SUM_W-1:0];
    assign sb   = sb_w[cmfuv_pkg::SUM_W-1:0];

    assign pu = cmfuv_pkg::DIV_W'(sa) * cmfuv_pkg::DIV_W'(cmfuv_pkg::SCALE_NUM);
    assign pv = cmfuv_pkg::DIV_W'(sb) * cmfuv_pkg::DIV_W'(cmfuv_pkg::SCALE_NUM);
    assign d  = cmfuv_pkg::DIV_W'(i_data.m) * cmfuv_pkg::DIV_W'(cmfuv_pkg::SCALE_DEN);

    always_comb begin
        n_data      = '0;
        n_data.face = i_data.face;
        n_data.zero = i_data.zero;
        // b = -m makes v exactly one, saturated at the end
        n_data.vsat = (sb == '0);
        n_data.d    = d;
        n_data.ru   = pu;
        n_data.rv   = n_data.vsat ? '0 : d - pv;
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/cmfuv_div_stage.sv
// one divider stage: a few restoring quotient bits for u and v
module cmfuv_div_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  cmfuv_pkg::t_div   i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output cmfuv_pkg::t_div   o_data
);

    logic [cmfuv_pkg::DIV_W:0] dx, r2u, r2v, tu, tv;
    logic                      geu, gev;
    logic                      r_valid;
    cmfuv_pkg::t_div           r_data;
    cmfuv_pkg::t_div           n_data;

    assign dx = {1'b0, i_data.d};

    // remainders stay below d, so the doubled value fits one extra bit
    always_comb begin
        n_data = i_data;
        r2u    = '0;
        r2v    = '0;
        tu     = '0;
        tv     = '0;
        geu    = 1'b0;
        gev    = 1'b0;
        for (int k = 0; k < cmfuv_pkg::STEPS_PER_STAGE; k++) begin
            r2u       = {n_data.ru, 1'b0};
            r2v       = {n_data.rv, 1'b0};
            tu        = r2u - dx;
            tv        = r2v - dx;
            geu       = (r2u >= dx);
            gev       = (r2v >= dx);
            n_data.ru = geu ? tu[cmfuv_pkg::DIV_W-1:0] : r2u[cmfuv_pkg::DIV_W-1:0];
            n_data.rv = gev ? tv[cmfuv_pkg::DIV_W-1:0] : r2v[cmfuv_pkg::DIV_W-1:0];
            n_data.qu = {n_data.qu[cmfuv_pkg::FRAC_BITS-2:0], geu};
            n_data.qv = {n_data.qv[cmfuv_pkg::FRAC_BITS-2:0], gev};
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

// File: src/cube_map_face_uv.sv
// top level of the cube map face selection and face uv pipeline
//
// Takes one signed Q1.14 direction vector per cycle, while o_stall is
// low, and returns the cube face (largest magnitude, ties to x then y
// then z) with u and v in unsigned Q0.16, v flipped. Ten register stages
// lie between input and output: one stage picks the face, one forms the
// scaled numerators and the divisor 1000*m, and eight stages of a
// pipelined restoring divider produce the 16 fraction bits of u and v,
// two bits per stage. Every stage holds its own item, so a new item is
// accepted in every cycle unless a stall has backed up to the input; a
// stall at the output only backs up as far as the pipeline is full, and
// empty stages still take items. A zero vector reports face -x, raises
// o_zero_direction and gives u and v as zero; v equal to one saturates
// to 65535.
module cube_map_face_uv (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    // direction item in
    input  logic                                      i_valid,
    output logic                                      o_stall,
    input  logic signed [cmfuv_pkg::IN_W-1:0]         i_dir_x,
    input  logic signed [cmfuv_pkg::IN_W-1:0]         i_dir_y,
    input  logic signed [cmfuv_pkg::IN_W-1:0]         i_dir_z,
    // face item out
    output logic                                      o_valid,
    input  logic                                      i_stall,
    output logic [2:0]                                o_face_index,
    output logic [cmfuv_pkg::COORD_W-1:0]             o_coord_u,
    output logic [cmfuv_pkg::COORD_W-1:0]             o_coord_v,
    output logic                                      o_zero_direction
);

    // bounds of u and v for a nonzero vector: 0.998 and 0.002 of full scale
    localparam logic [cmfuv_pkg::COORD_W-1:0] U_MAX = 16'd65405;
    localparam logic [cmfuv_pkg::COORD_W-1:0] V_MIN = 16'd131;

    logic            sel_ready;
    logic            sel_valid;
    cmfuv_pkg::t_sel sel_data;
    logic            prep_ready;

    // index 0 is the prep output, index DIV_STAGES the last divider stage
    cmfuv_pkg::t_div div_data  [cmfuv_pkg::DIV_STAGES+1];
    logic            div_valid [cmfuv_pkg::DIV_STAGES+1];
    logic            div_ready [cmfuv_pkg::DIV_STAGES+1];

    cmfuv_pkg::t_div last;

    cmfuv_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (sel_ready),
        .i_x     (i_dir_x),
        .i_y     (i_dir_y),
        .i_z     (i_dir_z),
        .o_valid (sel_valid),
        .i_ready (prep_ready),
        .o_data  (sel_data)
    );

    cmfuv_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sel_valid),
        .o_ready (prep_ready),
        .i_data  (sel_data),
        .o_valid (div_valid[0]),
        .i_ready (div_ready[0]),
        .o_data  (div_data[0])
    );

    for (genvar g = 0; g < cmfuv_pkg::DIV_STAGES; g++) begin : g_div
        cmfuv_div_stage u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[g]),
            .o_ready (div_ready[g]),
            .i_data  (div_data[g]),
            .o_valid (div_valid[g+1]),
            .i_ready (div_ready[g+1]),
            .o_data  (div_data[g+1])
        );
    end

    // the last stage is the output register
    assign div_ready[cmfuv_pkg::DIV_STAGES] = !i_stall;
    assign last    = div_data[cmfuv_pkg::DIV_STAGES];
    assign o_stall = !sel_ready;
    assign o_valid = div_valid[cmfuv_pkg::DIV_STAGES];

    assign o_face_index     = last.face;
    assign o_zero_direction = last.zero;
    // zero vector forces both coordinates to zero
    assign o_coord_u = last.zero ? '0 : last.qu;
    assign o_coord_v = last.zero ? '0 : (last.vsat ? '1 : last.qv);

`ifndef SYNTHESIS
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_face_index <= cmfuv_pkg::FACE_NEG_Z)
        else $error("face index out of range");

    a_zero_face: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_zero_direction |-> o_face_index == cmfuv_pkg::FACE_NEG_X)
        else $error("zero vector not on -x face");

    a_u_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_direction |-> o_coord_u <= U_MAX)
        else $error("u above scaled bound");

    a_v_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_zero_direction |-> o_coord_v >= V_MIN)
        else $error("v below scaled bound");
`endif

endmodule
